[sv/i2a_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helpers for the integer-to-ASCII formatter.
// No dependencies; imported by every module of the block.
package i2a_pkg;

  localparam int NUM_DIGITS = 10;
  localparam int DIGIT_W    = 4;
  localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
  localparam int VALUE_W    = 32;

  localparam logic [1:0] FMT_SDEC = 2'd0;
  localparam logic [1:0] FMT_UDEC = 2'd1;
  localparam logic [1:0] FMT_LHEX = 2'd2;
  localparam logic [1:0] FMT_UHEX = 2'd3;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_LOWER = 8'h61;
  localparam logic [7:0] CHAR_UPPER = 8'h41;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [VALUE_W-1:0] value;
  } i2a_in_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
    logic [3:0] char_count;
  } i2a_out_t;

  // Digits handed from the converter to the emitter, most significant digit on top.
  typedef struct packed {
    logic [BCD_W-1:0] digits;
    logic             neg;
    logic             upper;
  } i2a_conv_t;

  // Add three to every BCD digit of five or more, ahead of a doubling shift.
  function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] bcd);
    logic [BCD_W-1:0] res;
    logic [DIGIT_W-1:0] d;
    res = bcd;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      d = bcd[i*DIGIT_W +: DIGIT_W];
      if (d >= 4'd5) begin
        res[i*DIGIT_W +: DIGIT_W] = d + 4'd3;
      end
    end
    return res;
  endfunction

  function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d, input logic upper);
    logic [7:0] res;
    if (d < 4'd10) begin
      res = CHAR_ZERO + {4'd0, d};
    end else if (upper) begin
      res = CHAR_UPPER + {4'd0, d - 4'd10};
    end else begin
      res = CHAR_LOWER + {4'd0, d - 4'd10};
    end
    return res;
  endfunction

endpackage

[sv/i2a_convert.sv]
`timescale 1ns / 1ps
// Bit-serial binary to BCD converter (shift and add three), with a direct
// nibble load for hex formats. Depends on i2a_pkg.
module i2a_convert
  import i2a_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  i2a_in_t   in_data,
  output logic      conv_valid,
  input  logic      conv_ready,
  output i2a_conv_t conv_data
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SHIFT = 2'd1;
  localparam logic [1:0] ST_HOLD  = 2'd2;

  logic [1:0]         state;
  logic [VALUE_W-1:0] bin;
  logic [BCD_W-1:0]   bcd;
  logic [BCD_W-1:0]   bcd_adj;
  logic [4:0]         cnt;
  logic               neg;
  logic               upper;
  logic               is_neg;

  assign is_neg  = (in_data.cmd == FMT_SDEC) && in_data.value[VALUE_W-1];
  assign bcd_adj = bcd_adjust(bcd);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            neg   <= is_neg;
            upper <= (in_data.cmd == FMT_UHEX);
            cnt   <= 5'd0;
            if (in_data.cmd == FMT_LHEX || in_data.cmd == FMT_UHEX) begin
              bcd   <= {{(BCD_W-VALUE_W){1'b0}}, in_data.value};
              state <= ST_HOLD;
            end else begin
              bin   <= is_neg ? (VALUE_W'(0) - in_data.value) : in_data.value;
              bcd   <= '0;
              state <= ST_SHIFT;
            end
          end
        end
        ST_SHIFT: begin
          // adjust, then double and pull in the next magnitude bit
          bcd <= {bcd_adj[BCD_W-2:0], bin[VALUE_W-1]};
          bin <= {bin[VALUE_W-2:0], 1'b0};
          cnt <= cnt + 5'd1;
          if (cnt == 5'(VALUE_W - 1)) begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (conv_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign in_ready   = (state == ST_IDLE);
  assign conv_valid = (state == ST_HOLD);
  assign conv_data  = '{digits: bcd, neg: neg, upper: upper};

endmodule

[sv/i2a_emit.sv]
`timescale 1ns / 1ps
// Digit emitter: drops leading zeros, sends the sign, then shifts out one
// character per beat into the output register. Depends on i2a_pkg.
module i2a_emit
  import i2a_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      conv_valid,
  output logic      conv_ready,
  input  i2a_conv_t conv_data,
  output logic      out_valid,
  input  logic      out_ready,
  output i2a_out_t  out_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SKIP = 2'd1;
  localparam logic [1:0] ST_SIGN = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]         state;
  logic [BCD_W-1:0]   dig;
  logic [3:0]         remain;
  logic [3:0]         total;
  logic               neg;
  logic               upper;
  logic               out_free;
  logic               load_beat;
  logic [DIGIT_W-1:0] top_digit;

  assign out_free   = !out_valid || out_ready;
  assign load_beat  = out_free && (state == ST_SIGN || state == ST_EMIT);
  assign top_digit  = dig[BCD_W-1 -: DIGIT_W];
  assign conv_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load_beat) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (conv_valid) begin
            dig    <= conv_data.digits;
            neg    <= conv_data.neg;
            upper  <= conv_data.upper;
            remain <= 4'(NUM_DIGITS);
            state  <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          // drop leading zeros, but always keep the final digit
          if (top_digit == '0 && remain != 4'd1) begin
            dig    <= dig << DIGIT_W;
            remain <= remain - 4'd1;
          end else begin
            total <= remain + {3'd0, neg};
            state <= neg ? ST_SIGN : ST_EMIT;
          end
        end
        ST_SIGN: begin
          if (out_free) begin
            out_data.char_code  <= CHAR_MINUS;
            out_data.last_char  <= 1'b0;
            out_data.char_count <= 4'd0;
            state               <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_data.char_code  <= digit_char(top_digit, upper);
            out_data.last_char  <= (remain == 4'd1);
            out_data.char_count <= (remain == 4'd1) ? total : 4'd0;
            dig                 <= dig << DIGIT_W;
            remain              <= remain - 4'd1;
            if (remain == 4'd1) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[sv/integer_to_ascii_formatter.sv]
`timescale 1ns / 1ps
// Integer-to-ASCII formatter: bit-serial converter feeding a digit emitter.
// Depends on i2a_pkg, i2a_convert and i2a_emit.
//
// Usage:
//   in channel  (in_valid/in_ready/in_data): one beat per number, carrying
//     cmd (0 signed dec, 1 unsigned dec, 2 lower hex, 3 upper hex) and value.
//   out channel (out_valid/out_ready/out_data): one beat per character, most
//     significant first; last_char marks the final one, which also carries
//     char_count (sign included). Other characters carry char_count 0.
// Operation:
//   Decimal values run through a shift-and-add-three converter, one bit per
//   cycle; hex values load directly. The emitter then skips each leading
//   zero digit, then sends each character. The converter takes the next
//   number once it hands the previous one to the emitter, so it can convert
//   the next number while the emitter still sends the characters of the
//   previous one.
// Reset (rst, synchronous) empties both stages and drops any pending beat.
// When out_ready is low the current character holds in the output register
// and the emitter and then the converter stall behind it.
module integer_to_ascii_formatter
  import i2a_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  i2a_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output i2a_out_t out_data
);

  logic      conv_valid;
  logic      conv_ready;
  i2a_conv_t conv_data;

  i2a_convert u_convert (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .conv_valid (conv_valid),
    .conv_ready (conv_ready),
    .conv_data  (conv_data)
  );

  i2a_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .conv_valid (conv_valid),
    .conv_ready (conv_ready),
    .conv_data  (conv_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

[sv/i2a_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the integer-to-ASCII formatter, bound to the top level.
// Depends on i2a_pkg.
module i2a_checker
  import i2a_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     in_valid,
  input logic     in_ready,
  input i2a_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input i2a_out_t out_data
);

  // a stalled character beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  a_count_only_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last_char |-> out_data.char_count == 4'd0)
    else $error("char_count set on a non-final character");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.last_char |-> out_data.char_count != 4'd0 &&
                                        out_data.char_count <= 4'd11)
    else $error("char_count out of range on final character");

  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.char_code == CHAR_MINUS |-> !out_data.last_char)
    else $error("sign emitted as final character");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted number");

endmodule

bind integer_to_ascii_formatter i2a_checker u_i2a_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[tb/ascii_text_checker.sv]
`timescale 1ns / 1ps
// Checker for the integer-to-ASCII formatter: it watches both channels and predicts
// the characters of every accepted number, then compares each output beat with them.
// Depends on i2a_pkg for the beat structs and the format and character constants.
module ascii_text_checker
  import i2a_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_ready,
  input  i2a_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  i2a_out_t out_data,
  output int       fail_count,
  output int       pending
);

  localparam logic [127:0] LOWER_DIGITS = "0123456789abcdef";
  localparam logic [127:0] UPPER_DIGITS = "0123456789ABCDEF";
  localparam int REPORT_LIMIT = 10;

  i2a_out_t due_chars[$];
  int mismatches = 0;

  // Queue the text of one number, most significant character first.
  function automatic void predict_text(input logic [1:0] fmt, input logic [31:0] value);
    logic [31:0]  mag;
    logic [127:0] glyphs;
    logic [7:0]   digs [10];
    logic [3:0]   d;
    logic         neg;
    int           nd;
    int           total;
    i2a_out_t     c;
    mag = value;
    neg = (fmt == FMT_SDEC) && value[31];
    if (neg) begin
      mag = 32'd0 - value;
    end
    glyphs = (fmt == FMT_UHEX) ? UPPER_DIGITS : LOWER_DIGITS;
    nd = 0;
    do begin
      if (fmt == FMT_LHEX || fmt == FMT_UHEX) begin
        d = mag[3:0];
        mag = mag >> 4;
      end else begin
        d = 4'(mag % 32'd10);
        mag = mag / 32'd10;
      end
      digs[nd] = glyphs[(15 - int'(d)) * 8 +: 8];
      nd++;
    end while (mag != 0 && nd < 10);
    total = nd + (neg ? 1 : 0);
    if (neg) begin
      c.char_code  = CHAR_MINUS;
      c.last_char  = 1'b0;
      c.char_count = 4'd0;
      due_chars.push_back(c);
    end
    for (int i = nd - 1; i >= 0; i--) begin
      c.char_code  = digs[i];
      c.last_char  = (i == 0);
      c.char_count = (i == 0) ? 4'(total) : 4'd0;
      due_chars.push_back(c);
    end
  endfunction

  always @(posedge clk) begin : watch_beats
    i2a_out_t want;
    if (!rst) begin
      // Predict before comparing so a same-edge beat still finds its character.
      if (in_valid && in_ready) begin
        predict_text(in_data.cmd, in_data.value);
      end
      if (out_valid && out_ready) begin
        if (due_chars.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("unexpected char beat: got code %h last %0d count %0d",
                     out_data.char_code, out_data.last_char, out_data.char_count);
          end
        end else begin
          want = due_chars.pop_front();
          if (want.char_code != out_data.char_code || want.last_char != out_data.last_char ||
              want.char_count != out_data.char_count) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("char beat mismatch: expected code %h last %0d count %0d, got %h %0d %0d",
                       want.char_code, want.last_char, want.char_count,
                       out_data.char_code, out_data.last_char, out_data.char_count);
            end
          end
        end
      end
    end
    fail_count <= mismatches;
    pending <= due_chars.size();
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Top of the formatter testbench: clock, reset, number stimulus, output back-pressure,
// watchdog and verdict. Depends on i2a_pkg, integer_to_ascii_formatter, ascii_text_checker.
module testbench;
  import i2a_pkg::*;

  localparam int HOLD_CYCLES    = 500;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int RANDOM_ITEMS   = 257;
  localparam int QUIET_ITEMS    = 40;

  logic     clk;
  logic     rst;
  logic     in_valid;
  logic     in_ready;
  i2a_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  i2a_out_t out_data;

  int fail_count;
  int pending;
  int idle_run = 0;
  bit quiet_tail = 1'b0;
  bit hold_request = 1'b0;
  bit held_once = 1'b0;

  integer_to_ascii_formatter dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  ascii_text_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Offer one number and hold it until the beat is taken.
  task automatic send_number(input logic [1:0] fmt, input logic [31:0] v);
    i2a_in_t beat;
    beat.cmd = fmt;
    beat.value = v;
    in_data <= beat;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_and_idle(input logic [1:0] fmt, input logic [31:0] v);
    send_number(fmt, v);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // Mix full-range values with small ones, short widths and digit-count boundaries.
  function automatic logic [31:0] random_value();
    logic [31:0] p;
    int k;
    p = 32'd1;
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 20);
      2: return $urandom >> $urandom_range(0, 31);
      3: begin
        if ($urandom_range(0, 1) == 0) begin
          k = $urandom_range(1, 9);
          repeat (k) p = p * 32'd10;
        end else begin
          k = $urandom_range(1, 7);
          p = 32'd1 << (4 * k);
        end
        return p + $urandom_range(0, 2) - 32'd1;
      end
      default: begin
        if ($urandom_range(0, 1) == 0) begin
          return 32'd0 - $urandom_range(0, 20);
        end
        return 32'h8000_0000 + $urandom_range(0, 20);
      end
    endcase
  endfunction

  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Output side: random ready bursts, one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request && !held_once) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held_once = 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Count cycles with no beat on either channel and stop with a mismatch past the limit.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_run <= 0;
    end else if (idle_run >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Zero, extremes and digit-count edges in every format.
    send_and_idle(FMT_SDEC, 32'd0);
    send_and_idle(FMT_UDEC, 32'd0);
    send_and_idle(FMT_LHEX, 32'd0);
    send_and_idle(FMT_UHEX, 32'd0);
    send_and_idle(FMT_SDEC, 32'h8000_0000);
    send_and_idle(FMT_UDEC, 32'h8000_0000);
    send_and_idle(FMT_SDEC, 32'h7fff_ffff);
    send_and_idle(FMT_SDEC, 32'hffff_ffff);
    send_and_idle(FMT_UDEC, 32'hffff_ffff);
    send_and_idle(FMT_LHEX, 32'hffff_ffff);
    send_and_idle(FMT_UHEX, 32'hffff_ffff);
    send_and_idle(FMT_SDEC, 32'd1);
    send_and_idle(FMT_UDEC, 32'd9);
    send_and_idle(FMT_UDEC, 32'd10);
    send_and_idle(FMT_LHEX, 32'd15);
    send_and_idle(FMT_UHEX, 32'd16);
    send_and_idle(FMT_UDEC, 32'd1_000_000_000);
    send_and_idle(FMT_SDEC, 32'd999_999_999);
    send_and_idle(FMT_LHEX, 32'hdead_beef);
    send_and_idle(FMT_UHEX, 32'hdead_beef);
    send_and_idle(FMT_LHEX, 32'habcd_ef01);
    send_and_idle(FMT_UHEX, 32'h1000_0000);
    send_and_idle(FMT_SDEC, 32'hffff_fff6);

    // Hold the output off while numbers keep coming, so the block backs up.
    hold_request <= 1'b1;
    repeat (30) send_number(2'($urandom_range(0, 3)), random_value());
    in_valid <= 1'b0;
    wait_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - QUIET_ITEMS) begin
        quiet_tail <= 1'b1;
      end
      send_and_idle(2'($urandom_range(0, 3)), random_value());
    end
    in_valid <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
